@@ src/sha_pkg.sv @@
// Package: SHA-256 constants, types and round functions.
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAw = 4;
  localparam int unsigned CntW = 61;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StRound = 7'b0000100,
    StFold  = 7'b0001000,
    StPad   = 7'b0010000,
    StEmit  = 7'b0100000,
    StInit  = 7'b1000000
  } state_e;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    r = '0;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

@@ src/sha_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/sha_round.sv @@
// Compression datapath: working variables a..h and one round per cycle while step_i is high.
module sha_round (
  input  logic               clk_i,
  input  logic               load_i,
  input  sha_pkg::word_t     init_i [8],
  input  logic               step_i,
  input  sha_pkg::word_t     kw_i,
  output sha_pkg::word_t     v_o [8]
);
  import sha_pkg::*;

  word_t v_q [8];
  word_t v_d [8];
  word_t t1, t2;

  always_comb begin
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kw_i;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_d = v_q;
    if (load_i) begin
      v_d = init_i;
    end else if (step_i) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

@@ src/sha256_message_hasher_unit.sv @@
// Top level: byte-stream SHA-256 hasher with digest output stream.
// Usage:
//  Slave channel s_axis carries one message byte per word in tdata; tuser
//  flags that the byte is present and tlast ends the message.
//  Master channel m_axis returns the eight digest words h0..h7, tlast on h7.
//  A byte goes through accept, block-memory read, then merge and write
//  back; a word with neither flag set is only accepted.
//  On the 64th byte of a block, compression runs: a load step, rounds
//  0..15 (one read, then the round), rounds 16..63 (four schedule reads
//  on the one memory read port, the write-back of w, then the round),
//  and a fold into the hash.
//  End of message pads byte by byte (read, then merge and write back),
//  then writes the two length words, using one or two blocks, then emits
//  eight words, one per cycle while m_axis is ready; s_axis_tready stays
//  low until h7 is taken and the initial hash is reloaded.
//  A stall on m_axis holds the current word; nothing is lost.
//  Reset loads the initial hash, clears counters; the block memory needs
//  no clearing as padding writes every entry before a compression.
module sha256_message_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhRd   = 4'b0010,
    PhWr   = 4'b0100,
    PhDone = 4'b1000
  } ph_e;

  state_e st_q, st_d;
  ph_e    ph_q, ph_d;
  word_t  h_q [8];
  logic   [5:0] pos_q;
  logic   [CntW-1:0] cnt_q;
  logic   fin_q, lenblk_q, pend_q;
  logic   [7:0] byte_q;
  logic   [6:0] rnd_q;
  logic   [1:0] sub_q;
  logic   [2:0] oidx_q;
  word_t  w_q;

  logic   we;
  logic   [BufAw-1:0] waddr, raddr;
  word_t  wdata, rdata;

  // block memory doubles as the rolling schedule window
  sha_ram #(.Width(WordW), .Depth(BufDepth)) u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic   rload, rstep;
  word_t  v [8];
  word_t  kw;
  sha_round u_round (
    .clk_i, .load_i(rload), .init_i(h_q), .step_i(rstep), .kw_i(kw), .v_o(v)
  );

  logic [63:0] bits;
  logic [5:0]  t6;
  logic [4:0]  shift;
  word_t       merged;

  assign bits  = {cnt_q, 3'b000};
  assign t6    = rnd_q[5:0];
  assign shift = 5'(24 - 8 * pos_q[1:0]);
  assign merged = (pos_q[1:0] == 2'd0 ? '0 : rdata) | (word_t'(byte_q) << shift);
  assign kw    = RoundK[t6] + w_q;

  assign s_axis_tready = (st_q == StIdle) && !pend_q;
  assign m_axis_tvalid = (st_q == StEmit);
  assign m_axis_tdata  = {5'd0, oidx_q, h_q[oidx_q]};
  assign m_axis_tlast  = (oidx_q == 3'd7);

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // byte step: read word, merge (old word dropped at word start), write
  // round step sub 0..3: read x[t], x[t-15], x[t-2], x[t-7]; then write w
  always_comb begin
    we = 1'b0;
    waddr = pos_q[5:2];
    wdata = merged;
    raddr = pos_q[5:2];
    rload = 1'b0;
    rstep = 1'b0;
    if (st_q == StRound) begin
      unique case (sub_q)
        2'd0: raddr = t6[3:0];
        2'd1: raddr = 4'(t6 - 6'd15);
        2'd2: raddr = 4'(t6 - 6'd2);
        2'd3: raddr = 4'(t6 - 6'd7);
        default: raddr = t6[3:0];
      endcase
    end else if (st_q == StLoad) begin
      rload = 1'b1;
    end
    if ((st_q == StIdle || st_q == StPad) && ph_q == PhWr) begin
      we = 1'b1;
    end
    if (st_q == StRound && rnd_q[6]) begin
      rstep = 1'b1;
    end
    if (st_q == StPad && lenblk_q) begin
      we = 1'b1;
      waddr = sub_q[0] ? 4'd15 : 4'd14;
      wdata = sub_q[0] ? bits[31:0] : bits[63:32];
    end
    if (st_q == StRound && !rnd_q[6] && sub_q == 2'd3 && ph_q == PhDone) begin
      we = 1'b1;
      waddr = t6[3:0];
      wdata = w_q;
    end
  end

  word_t x0_q, x15_q, x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit;
      ph_q <= PhIdle;
      pos_q <= '0;
      cnt_q <= '0;
      fin_q <= 1'b0;
      lenblk_q <= 1'b0;
      pend_q <= 1'b0;
      rnd_q <= '0;
      sub_q <= '0;
      oidx_q <= '0;
      byte_q <= '0;
      w_q <= '0;
      x0_q <= '0;
      x15_q <= '0;
      x2_q <= '0;
    end else begin
      unique case (st_q)
        StInit: begin
          st_q <= StIdle;
        end
        StIdle: begin
          unique case (ph_q)
            PhIdle: begin
              if (in_acc) begin
                fin_q <= s_axis_tlast;
                if (s_axis_tuser) begin
                  byte_q <= s_axis_tdata;
                  cnt_q <= cnt_q + 1'b1;
                  ph_q <= PhRd;
                  pend_q <= 1'b1;
                end else if (s_axis_tlast) begin
                  byte_q <= 8'h80;
                  st_q <= StPad;
                  ph_q <= PhRd;
                  pend_q <= 1'b1;
                end
              end
            end
            PhRd: ph_q <= PhWr;
            PhWr: begin
              pos_q <= pos_q + 1'b1;
              if (pos_q == 6'd63) begin
                // pad byte ready in case the message ends here
                byte_q <= 8'h80;
                ph_q <= PhIdle;
                st_q <= StLoad;
              end else if (fin_q) begin
                byte_q <= 8'h80;
                st_q <= StPad;
                ph_q <= PhRd;
              end else begin
                ph_q <= PhIdle;
                pend_q <= 1'b0;
              end
            end
            default: ph_q <= PhIdle;
          endcase
        end
        StPad: begin
          if (lenblk_q) begin
            if (sub_q[0]) begin
              sub_q <= '0;
              pos_q <= '0;
              st_q <= StLoad;
            end else begin
              sub_q <= sub_q + 1'b1;
            end
          end else begin
            unique case (ph_q)
              PhRd: ph_q <= PhWr;
              PhWr: begin
                byte_q <= 8'h00;
                pos_q <= pos_q + 1'b1;
                if (pos_q == 6'd55) begin
                  lenblk_q <= 1'b1;
                  ph_q <= PhIdle;
                end else if (pos_q == 6'd63) begin
                  st_q <= StLoad;
                  ph_q <= PhIdle;
                end else begin
                  ph_q <= PhRd;
                end
              end
              default: ph_q <= PhRd;
            endcase
          end
        end
        StLoad: begin
          rnd_q <= '0;
          sub_q <= '0;
          ph_q <= PhRd;
          st_q <= StRound;
        end
        StRound: begin
          if (rnd_q[6]) begin
            // apply round with w_q, then next
            rnd_q <= {1'b0, 6'(t6 + 6'd1)};
            sub_q <= '0;
            ph_q <= PhRd;
            if (t6 == 6'd63) begin
              st_q <= StFold;
            end
          end else begin
            // read pipeline: data read for sub k appears in the PhWr phase of sub k
            unique case (ph_q)
              PhRd: begin
                ph_q <= PhWr;
              end
              PhWr: begin
                unique case (sub_q)
                  2'd0: begin
                    x0_q <= rdata;
                    if (t6 < 6'd16) begin
                      w_q <= rdata;
                      rnd_q[6] <= 1'b1;
                    end else begin
                      sub_q <= 2'd1;
                      ph_q <= PhRd;
                    end
                  end
                  2'd1: begin
                    x15_q <= rdata;
                    sub_q <= 2'd2;
                    ph_q <= PhRd;
                  end
                  2'd2: begin
                    x2_q <= rdata;
                    sub_q <= 2'd3;
                    ph_q <= PhRd;
                  end
                  2'd3: begin
                    w_q <= x0_q + ssig0(x15_q) + rdata + ssig1(x2_q);
                    ph_q <= PhDone;
                  end
                  default: sub_q <= '0;
                endcase
              end
              PhDone: begin
                // w_q is written back to the window in this cycle
                ph_q <= PhIdle;
                rnd_q[6] <= 1'b1;
              end
              default: ph_q <= PhRd;
            endcase
          end
        end
        StFold: begin
          pos_q <= '0;
          if (lenblk_q) begin
            lenblk_q <= 1'b0;
            fin_q <= 1'b0;
            oidx_q <= '0;
            st_q <= StEmit;
          end else if (fin_q) begin
            ph_q <= PhRd;
            st_q <= StPad;
          end else begin
            ph_q <= PhIdle;
            pend_q <= 1'b0;
            st_q <= StIdle;
          end
        end
        StEmit: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 1'b1;
            if (oidx_q == 3'd7) begin
              cnt_q <= '0;
              pend_q <= 1'b0;
              ph_q <= PhIdle;
              st_q <= StInit;
            end
          end
        end
        default: st_q <= StInit;
      endcase
    end
  end

  // chaining value; reloaded in the init step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else if (st_q == StInit) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else if (st_q == StFold) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_out_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("out while accepting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(oidx_q)) else $error("index moved");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("extra word");
`endif

endmodule

@@ tb/testbench.sv @@
// Testbench for the byte-stream SHA-256 hasher: scoreboard with its own hash model, random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  localparam logic [31:0] IvTab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  int errors;
  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH: %s", what);
  endtask

  class digest_scoreboard;
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    int          pos;
    logic [60:0] nbytes;
    digest_t     pending [$];
    int          digests_seen;

    function new();
      hv = IvTab;
      pos = 0;
      nbytes = '0;
      digests_seen = 0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, x15, x2;
      w = blk;
      v = hv;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          x15 = w[(t - 15) & 15];
          x2 = w[(t - 2) & 15];
          wt = w[t & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[(t - 7) & 15]
             + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
          w[t & 15] = wt;
        end
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + wt;
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
    endfunction

    function void push_byte(logic [7:0] b);
      if (pos[1:0] == 0) blk[pos >> 2] = '0;
      blk[pos >> 2] |= 32'(b) << (24 - 8 * pos[1:0]);
      pos++;
      if (pos == 64) begin
        compress();
        pos = 0;
      end
    endfunction

    function void note_input(logic [7:0] b, logic present, logic eom);
      logic [63:0] bits;
      digest_t     dw;
      if (present) begin
        push_byte(b);
        nbytes = nbytes + 61'd1;
      end
      if (eom) begin
        bits = {nbytes, 3'b000};
        push_byte(8'h80);
        while (pos != 56) push_byte(8'h00);
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        compress();
        pos = 0;
        for (int i = 0; i < 8; i++) begin
          dw.word = hv[i];
          dw.idx = 3'(i);
          dw.last = (i == 7);
          pending = {pending, dw};
        end
        hv = IvTab;
        nbytes = '0;
      end
    endfunction

    task check_result(logic [39:0] d, logic l);
      digest_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.word)
        report_mismatch($sformatf("h%0d: got %h want %h", e.idx, d[31:0], e.word));
      if (d[34:32] !== e.idx)
        report_mismatch($sformatf("index: got %0d want %0d", d[34:32], e.idx));
      if (d[39:35] !== 5'b0) report_mismatch("nonzero fill bits");
      if (l !== e.last) report_mismatch($sformatf("tlast on h%0d: got %b", e.idx, l));
      if (e.last) digests_seen++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  sha256_message_hasher_unit u_dut (.*);

  digest_scoreboard sb = new();
  int cycles;
  int sent_items;
  bit stall_on;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("sha256_message_hasher_unit regression: fail");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // receiver: stall pattern switches between none, light and heavy stalls
  int stall_mode;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  int burst_left;
  task automatic send_word(logic [7:0] b, logic present, logic eom);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= present;
    s_axis_tlast <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1)) send_word(8'($urandom), 1'b0, 1'b1);
    else send_word(8'($urandom), 1'b1, 1'b1);
  endtask

  initial begin
    int n;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // empty message, idle item then end, byte extremes, abc and a two-byte message
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b1);
    // random messages, mostly short, a few spanning blocks or padding edges
    while (sent_items < 215) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(54, 57);
        1: n = $urandom_range(60, 70);
        2: n = 0;
        default: n = $urandom_range(1, 12);
      endcase
      send_message(n);
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("sent %0d input words, checked %0d digests under random stalls",
             sent_items, sb.digests_seen);
    if (errors == 0) begin
      $display("sha256_message_hasher_unit regression: pass");
    end else begin
      $display("sha256_message_hasher_unit regression: fail");
    end
    $finish;
  end
endmodule
